// File: design/mac_pkg.sv
// shared types and constants for the multiply-accumulate peripheral
// register codes, the idle mode code, sum extension values and the control struct
// no dependencies
`default_nettype none

package mac_pkg;

  // register map, also the mode codes of the four first-operand registers
  typedef enum logic [2:0] {
    REG_MPY    = 3'd0,
    REG_MPYS   = 3'd1,
    REG_MAC    = 3'd2,
    REG_MACS   = 3'd3,
    REG_OP2    = 3'd4,
    REG_RESLO  = 3'd5,
    REG_RESHI  = 3'd6,
    REG_SUMEXT = 3'd7
  } reg_idx_t;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned ACC_W  = 2 * WORD_W;
  localparam int unsigned NUM_REGS = 8;

  // mode register value when no operation has been selected
  localparam logic [2:0] MODE_NONE = 3'd4;

  localparam logic [WORD_W-1:0] SUMEXT_NEG   = 16'hFFFF;
  localparam logic [WORD_W-1:0] SUMEXT_CARRY = 16'h0001;
  localparam logic [WORD_W-1:0] SUMEXT_ZERO  = 16'h0000;

  // operation control handed to the arithmetic unit
  typedef struct packed {
    logic [2:0] mode;
    logic       first_is_byte;
    logic       second_is_byte;
  } calc_ctrl_t;

endpackage

`default_nettype wire

// File: design/mac_calc.sv
// multiply and accumulate datapath: operand extension, 17x17 signed multiply,
// 32-bit accumulate and sum extension
// depends on mac_pkg
`default_nettype none

module mac_calc (
  input  mac_pkg::calc_ctrl_t ctrl,
  input  logic [15:0]         op1,
  input  logic [15:0]         op2,
  input  logic [31:0]         acc,
  output logic                run,
  output logic [31:0]         sum,
  output logic [15:0]         sumext
);
  import mac_pkg::*;

  // byte operands use the low byte; sign only counts in the signed modes
  function automatic logic [16:0] extend_op(input logic [15:0] w, input logic is_byte,
                                            input logic is_signed);
    logic [16:0] v;
    if (is_byte) begin
      v = {{9{is_signed & w[7]}}, w[7:0]};
    end else begin
      v = {is_signed & w[15], w};
    end
    return v;
  endfunction

  logic        is_signed;
  logic        is_acc;
  logic [16:0] a_ext;
  logic [16:0] b_ext;
  logic [31:0] prod32;
  logic [32:0] acc_sum;

  assign run       = (ctrl.mode != MODE_NONE);
  assign is_signed = (ctrl.mode == REG_MPYS) || (ctrl.mode == REG_MACS);
  assign is_acc    = (ctrl.mode == REG_MAC) || (ctrl.mode == REG_MACS);

  assign a_ext = extend_op(op1, ctrl.first_is_byte, is_signed);
  assign b_ext = extend_op(op2, ctrl.second_is_byte, is_signed);

  // 17x17 signed covers both the signed and the zero-extended case; only the
  // low 32 bits of the product are kept
  assign prod32 = 32'($signed(a_ext) * $signed(b_ext));

  // accumulate with carry out of bit 31
  assign acc_sum = {1'b0, acc} + {1'b0, prod32};
  assign sum     = is_acc ? acc_sum[31:0] : prod32;

  // sign or carry report
  always_comb begin
    case (ctrl.mode) inside
      REG_MPYS, REG_MACS: sumext = sum[31] ? SUMEXT_NEG : SUMEXT_ZERO;
      REG_MAC:            sumext = acc_sum[32] ? SUMEXT_CARRY : SUMEXT_ZERO;
      default:            sumext = SUMEXT_ZERO;
    endcase
  end

endmodule

`default_nettype wire

// File: design/multiply_accumulate_peripheral.sv
// top level of the multiply-accumulate peripheral: access register, register
// file, operation control and read data register
// depends on mac_pkg and mac_calc
//
// Usage: every bus access is one word on the input channel (in_valid/in_stall)
// carrying mode (0 read, 1 write), reg_index, high_byte, byte_access and
// write_data. Every access returns one word on the output channel
// (out_valid/out_stall): the register word or addressed byte for a read,
// zero for a write.
// An accepted word sits in the access register until the output side is
// ready; that advance updates the register file and captures the read data.
// Throughput is one access per cycle while the receiver does not stall; a
// write to op2 multiplies (and accumulates) combinationally, through one
// 17x17 multiplier and a 33-bit adder, in the step that updates the register
// file, so a following read of the result sees the new value.
// When the receiver stalls, the read data register holds its word and the
// access register fills; a further access is then stalled upstream.
// Reset (rst, synchronous) clears all registers to zero, deselects the mode
// and empties both stages.
`default_nettype none

module multiply_accumulate_peripheral (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [2:0]  reg_index,
  input  logic        high_byte,
  input  logic        byte_access,
  input  logic [15:0] write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] read_data
);
  import mac_pkg::*;

  // access register
  logic        s1_valid;
  logic        s1_write;
  logic [2:0]  s1_idx;
  logic        s1_hi;
  logic        s1_byte;
  logic [15:0] s1_data;

  // architectural state
  logic [15:0] reg_file [NUM_REGS];
  logic [15:0] reg_file_next [NUM_REGS];
  logic [15:0] op1_word;
  logic [15:0] op1_word_next;
  logic [2:0]  current_mode;
  logic [2:0]  current_mode_next;
  logic        first_is_byte;
  logic        first_is_byte_next;
  logic        second_is_byte;
  logic        second_is_byte_next;

  logic        s2_ready;
  logic        adv;
  logic [15:0] old_word;
  logic [15:0] new_word;
  logic [15:0] rd_word;
  logic [15:0] result_word;

  calc_ctrl_t  ctrl;
  logic        calc_run;
  logic [31:0] calc_sum;
  logic [15:0] calc_sumext;

  // handshake
  assign s2_ready = !out_valid || !out_stall;
  assign adv      = s1_valid && s2_ready;
  assign in_stall = s1_valid && !s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_write <= mode;
      s1_idx   <= reg_index;
      s1_hi    <= high_byte;
      s1_byte  <= byte_access;
      s1_data  <= write_data;
    end
  end

  // merged write word: low byte write clears the upper byte
  assign old_word = reg_file[s1_idx];
  always_comb begin
    if (!s1_byte) begin
      new_word = s1_data;
    end else if (s1_hi) begin
      new_word = {s1_data[7:0], old_word[7:0]};
    end else begin
      new_word = {8'h00, s1_data[7:0]};
    end
  end

  // arithmetic sees the freshly written second operand
  assign ctrl.mode           = current_mode;
  assign ctrl.first_is_byte  = first_is_byte;
  assign ctrl.second_is_byte = s1_byte;

  mac_calc u_calc (
    .ctrl   (ctrl),
    .op1    (op1_word),
    .op2    (new_word),
    .acc    ({reg_file[REG_RESHI], reg_file[REG_RESLO]}),
    .run    (calc_run),
    .sum    (calc_sum),
    .sumext (calc_sumext)
  );

  // register write decode
  always_comb begin
    reg_file_next       = reg_file;
    op1_word_next       = op1_word;
    current_mode_next   = current_mode;
    first_is_byte_next  = first_is_byte;
    second_is_byte_next = second_is_byte;
    if (s1_write) begin
      unique case (s1_idx) inside
        REG_MPY, REG_MPYS, REG_MAC, REG_MACS: begin
          reg_file_next[s1_idx] = new_word;
          op1_word_next         = new_word;
          current_mode_next     = s1_idx;
          first_is_byte_next    = s1_byte;
        end
        REG_OP2: begin
          reg_file_next[REG_OP2] = new_word;
          second_is_byte_next    = s1_byte;
          if (calc_run) begin
            reg_file_next[REG_RESLO]  = calc_sum[15:0];
            reg_file_next[REG_RESHI]  = calc_sum[31:16];
            reg_file_next[REG_SUMEXT] = calc_sumext;
          end
        end
        REG_RESLO, REG_RESHI: begin
          reg_file_next[s1_idx] = new_word;
        end
        default: begin
          // sum extension is read-only
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        reg_file[i] <= '0;
      end
      op1_word       <= '0;
      current_mode   <= MODE_NONE;
      first_is_byte  <= 1'b0;
      second_is_byte <= 1'b0;
    end else if (adv) begin
      reg_file       <= reg_file_next;
      op1_word       <= op1_word_next;
      current_mode   <= current_mode_next;
      first_is_byte  <= first_is_byte_next;
      second_is_byte <= second_is_byte_next;
    end
  end

  // read data: word, or addressed byte in the low half
  always_comb begin
    if (!s1_byte) begin
      rd_word = old_word;
    end else if (s1_hi) begin
      rd_word = {8'h00, old_word[15:8]};
    end else begin
      rd_word = {8'h00, old_word[7:0]};
    end
  end
  assign result_word = s1_write ? 16'h0000 : rd_word;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      read_data <= result_word;
    end
  end

  // a write always answers with zero
  assert property (@(posedge clk) disable iff (rst)
    (adv && s1_write) |=> (out_valid && read_data == 16'h0000))
    else $error("write access did not return zero");

  // starting with no mode selected leaves the result untouched
  assert property (@(posedge clk) disable iff (rst)
    (adv && s1_write && s1_idx == REG_OP2 && current_mode == MODE_NONE)
    |=> ($stable(reg_file[REG_RESLO]) && $stable(reg_file[REG_RESHI])))
    else $error("result changed with no mode selected");

  // unsigned multiply never reports a sign or carry
  assert property (@(posedge clk) disable iff (rst)
    (adv && s1_write && s1_idx == REG_OP2 && current_mode == REG_MPY)
    |=> (reg_file[REG_SUMEXT] == SUMEXT_ZERO))
    else $error("sum extension set by unsigned multiply");

  // upstream is only held off while the access register is full
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("stall without a full pipeline");

  // the first operand copy tracks the selected register
  assert property (@(posedge clk) disable iff (rst)
    (current_mode != MODE_NONE) |-> (op1_word == reg_file[current_mode]))
    else $error("first operand copy out of step");

endmodule

`default_nettype wire
